>>> sv/dwwp_pkg.sv
// Package for the distance weighted waypoint pick block.
// Holds payload structs, command/status codes, controller state and command structs.
`default_nettype none
package dwwp_pkg;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_PICK  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_LOADED   = 3'd0,
		ST_PICKED   = 3'd1,
		ST_CLEARED  = 3'd2,
		ST_EMPTY    = 3'd3,
		ST_ZERO     = 3'd4,
		ST_FULL     = 3'd5,
		ST_RSVD6    = 3'd6,
		ST_RSVD7    = 3'd7
	} status_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic [31:0]        rand_frac;
	} in_item_t;

	typedef struct packed {
		logic signed [23:0] pick_x;
		logic signed [23:0] pick_y;
		logic [5:0]         pick_index;
		logic [2:0]         status;
		logic [6:0]         remaining;
	} out_item_t;

	localparam logic [15:0] EXPONENT_RESET = 16'd4096;

	typedef enum logic [3:0] {
		S_IDLE,
		S_WREAD,
		S_WSQ,
		S_WLOG,
		S_WMUL,
		S_WEXP,
		S_THR0,
		S_THR1,
		S_SREAD,
		S_SCHK,
		S_MREAD,
		S_MWRITE,
		S_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic latch_in;
		logic clr_idx;
		logic inc_idx;
		logic rd_wp;
		logic wr_load;
		logic sq;
		logic lg;
		logic mul;
		logic wexp;
		logic thr0;
		logic thr1;
		logic rd_w;
		logic cum;
		logic set_sel;
		logic set_last;
		logic rd_shift;
		logic wr_shift;
		logic dec_count;
		logic clr_count;
		logic res;
		logic [2:0] res_status;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		cmd_t cmd;
		logic empty;
		logic full;
		logic idx_last;
		logic zero;
		logic cum_gt;
		logic shift_done;
	} dp_stat_t;

endpackage
`default_nettype wire

>>> sv/dwwp_ctrl.sv
// Controller state machine for the distance weighted waypoint pick block.
// Depends on dwwp_pkg; drives dwwp_dp through command/status structs.
`default_nettype none
module dwwp_ctrl
	import dwwp_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_fire,
	input  wire logic     out_busy,
	input  wire dp_stat_t stat,
	output logic          in_ready,
	output logic          out_load,
	output dp_cmd_t       cmd_o
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_fire) state_d = S_DONE;
			S_DONE: begin
				if (!out_busy) begin
					state_d = S_IDLE;
					unique case (stat.cmd)
						CMD_PICK: if (!stat.empty) state_d = S_WREAD;
						CMD_NONE: state_d = S_IDLE;
						default: ;
					endcase
				end
			end
			S_WREAD: state_d = S_WSQ;
			S_WSQ:   state_d = S_WLOG;
			S_WLOG:  state_d = stat.zero ? S_IDLE : S_WMUL;
			S_WMUL:  state_d = S_WEXP;
			S_WEXP:  state_d = stat.idx_last ? S_THR0 : S_WREAD;
			S_THR0:  state_d = S_THR1;
			S_THR1:  state_d = S_SREAD;
			S_SREAD: state_d = S_SCHK;
			S_SCHK:  state_d = (stat.cum_gt || stat.idx_last) ? S_MREAD : S_SREAD;
			S_MREAD: state_d = S_MWRITE;
			S_MWRITE: state_d = stat.shift_done ? S_IDLE : S_MREAD;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd_o    = '0;
		in_ready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd_o.latch_in = in_fire;
			end
			S_DONE: begin
				cmd_o.clr_idx = 1'b1;
				if (!out_busy) begin
					unique case (stat.cmd)
						CMD_LOAD: begin
							out_load = 1'b1;
							cmd_o.res = 1'b1;
							if (stat.full) cmd_o.res_status = ST_FULL;
							else begin
								cmd_o.wr_load    = 1'b1;
								cmd_o.res_status = ST_LOADED;
							end
						end
						CMD_CLEAR: begin
							out_load = 1'b1;
							cmd_o.res = 1'b1;
							cmd_o.clr_count = 1'b1;
							cmd_o.res_status = ST_CLEARED;
						end
						CMD_PICK: if (stat.empty) begin
							out_load = 1'b1;
							cmd_o.res = 1'b1;
							cmd_o.res_status = ST_EMPTY;
						end
						default: ;
					endcase
				end
			end
			S_WREAD: cmd_o.rd_wp = 1'b1;
			S_WSQ:   cmd_o.sq = 1'b1;
			S_WLOG: begin
				cmd_o.lg = 1'b1;
				if (stat.zero) begin
					out_load = 1'b1;
					cmd_o.res = 1'b1;
					cmd_o.res_status = ST_ZERO;
				end
			end
			S_WMUL: cmd_o.mul = 1'b1;
			S_WEXP: begin
				cmd_o.wexp = 1'b1;
				if (stat.idx_last) cmd_o.clr_idx = 1'b1;
				else cmd_o.inc_idx = 1'b1;
			end
			S_THR0: cmd_o.thr0 = 1'b1;
			S_THR1: cmd_o.thr1 = 1'b1;
			S_SREAD: begin
				// coordinates ride along so the chosen entry is held before the shift
				cmd_o.rd_w  = 1'b1;
				cmd_o.rd_wp = 1'b1;
			end
			S_SCHK: begin
				cmd_o.cum = 1'b1;
				if (stat.cum_gt) cmd_o.set_sel = 1'b1;
				else if (stat.idx_last) cmd_o.set_last = 1'b1;
				else cmd_o.inc_idx = 1'b1;
			end
			S_MREAD: cmd_o.rd_shift = 1'b1;
			S_MWRITE: begin
				cmd_o.wr_shift = 1'b1;
				if (stat.shift_done) begin
					cmd_o.dec_count = 1'b1;
					out_load = 1'b1;
					cmd_o.res = 1'b1;
					cmd_o.res_status = ST_PICKED;
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

>>> sv/dwwp_dp.sv
// Datapath for the distance weighted waypoint pick block: waypoint and weight
// memories, squared distance, log2/exp2 weight, threshold, search and shift.
// Depends on dwwp_pkg; sequenced by dwwp_ctrl.
`default_nettype none
module dwwp_dp
	import dwwp_pkg::*;
#(
	parameter int MAX_WAYPOINTS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire in_item_t    in_item,
	input  wire logic [15:0] exponent,
	input  wire dp_cmd_t     cmd_i,
	output dp_stat_t         stat,
	output out_item_t        res
);

	localparam int AW = $clog2(MAX_WAYPOINTS);
	localparam int CW = $clog2(MAX_WAYPOINTS + 1);
	localparam int SW = 32 + CW;
	localparam logic [CW-1:0] MAXC = CW'(MAX_WAYPOINTS);

	logic [23:0] x_mem [MAX_WAYPOINTS];
	logic [23:0] y_mem [MAX_WAYPOINTS];
	logic [31:0] w_mem [MAX_WAYPOINTS];

	in_item_t     in_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] idx_q, sel_q;
	logic [23:0]  rx_q, ry_q;
	logic [23:0]  pick_x_q, pick_y_q;
	logic [31:0]  rw_q;
	logic [48:0]  sqx_q, sqy_q;
	logic         d2_zero;
	logic signed [23:0] lg_q;
	logic signed [40:0] s_q;
	logic [SW-1:0] sum_q;
	logic [63:0]  p0_q;
	logic [SW-1:0] thr_q;
	logic [SW-1:0] cum_q;
	logic [SW-1:0] cum_n;
	logic [AW-1:0] sidx;
	logic [31:0]  wt;

	// memory reads/writes
	always_ff @(posedge clk) begin
		if (cmd_i.wr_load) begin
			x_mem[count_q[AW-1:0]] <= in_q.pos_x;
			y_mem[count_q[AW-1:0]] <= in_q.pos_y;
		end
		if (cmd_i.wr_shift) begin
			x_mem[sidx] <= rx_q;
			y_mem[sidx] <= ry_q;
		end
		if (cmd_i.rd_wp || cmd_i.rd_shift) begin
			rx_q <= x_mem[cmd_i.rd_shift ? sidx + AW'(1) : idx_q];
			ry_q <= y_mem[cmd_i.rd_shift ? sidx + AW'(1) : idx_q];
		end
		if (cmd_i.wexp) w_mem[idx_q] <= wt;
		if (cmd_i.rd_w) rw_q <= w_mem[idx_q];
	end

	// shift walks from sel toward count-1
	logic [AW-1:0] shift_q;
	assign sidx = shift_q;
	logic [CW-1:0] shift_next;
	assign shift_next = CW'(shift_q) + CW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd_i.clr_idx) idx_q <= '0;
			else if (cmd_i.inc_idx) idx_q <= idx_q + AW'(1);
			if (cmd_i.clr_count) count_q <= '0;
			else if (cmd_i.wr_load) count_q <= count_q + CW'(1);
			else if (cmd_i.dec_count) count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_i.latch_in) in_q <= in_item;
		if (cmd_i.set_sel || cmd_i.set_last) begin
			sel_q    <= idx_q;
			shift_q  <= idx_q;
			pick_x_q <= rx_q;
			pick_y_q <= ry_q;
		end else if (cmd_i.wr_shift) begin
			shift_q <= shift_q + AW'(1);
		end
		if (cmd_i.wexp) sum_q <= sum_q + SW'(wt);
		else if (cmd_i.clr_idx) sum_q <= '0;
		if (cmd_i.clr_idx || cmd_i.thr0) cum_q <= '0;
		else if (cmd_i.cum) cum_q <= cum_n;
	end

	// squares
	logic signed [24:0] dx, dy;
	logic [24:0] ax, ay;
	always_comb begin
		dx = 25'(signed'(rx_q)) - 25'(in_q.pos_x);
		dy = 25'(signed'(ry_q)) - 25'(in_q.pos_y);
		ax = dx[24] ? 25'(-dx) : 25'(dx);
		ay = dy[24] ? 25'(-dy) : 25'(dy);
	end
	always_ff @(posedge clk) begin
		if (cmd_i.sq) begin
			sqx_q <= 49'(ax * ax);
			sqy_q <= 49'(ay * ay);
		end
	end
	logic [49:0] d2;
	assign d2 = 50'(sqx_q) + 50'(sqy_q);

	// log2 of d2: leading one search plus fraction alignment
	logic [5:0] k;
	logic [49:0] rest;
	logic [15:0] frac;
	always_comb begin
		k = '0;
		for (int b = 0; b < 50; b++) if (d2[b]) k = 6'(b);
		rest = d2 & ~(50'd1 << k);
		if (k >= 6'd16) frac = 16'(rest >> (k - 6'd16));
		else frac = 16'(rest << (6'd16 - k));
	end
	always_ff @(posedge clk) begin
		if (cmd_i.lg) lg_q <= signed'({2'b00, k, frac}) - 24'sd1048576;
		if (cmd_i.mul) s_q <= signed'({25'd0, exponent}) * 41'(lg_q);
	end
	assign d2_zero = (d2 == '0);

	// exp2 weight
	logic [11:0] nsh;
	logic [28:0] fr;
	logic [32:0] m;
	logic [32:0] wsh;
	always_comb begin
		nsh = 12'(s_q[40:29]);
		fr  = s_q[28:0];
		m   = 33'h1_0000_0000 - {2'b00, fr, 2'b00};
		wsh = (nsh >= 12'd33) ? 33'd0 : (m >> nsh[5:0]);
		if (s_q <= 0) wt = 32'hFFFF_FFFF;
		else if (wsh[32]) wt = 32'hFFFF_FFFF;
		else if (wsh == '0) wt = 32'd1;
		else wt = wsh[31:0];
	end
	always_ff @(posedge clk) begin
		if (cmd_i.thr0) p0_q <= 64'(in_q.rand_frac) * 64'(sum_q[31:0]);
		if (cmd_i.thr1) thr_q <= SW'(in_q.rand_frac * sum_q[SW-1:32]) + SW'(p0_q[63:32]);
	end

	assign cum_n = cum_q + SW'(rw_q);

	// result register
	always_ff @(posedge clk) begin
		if (cmd_i.res) begin
			res.status <= cmd_i.res_status;
			if (cmd_i.res_status == ST_PICKED) begin
				res.pick_x     <= pick_x_q;
				res.pick_y     <= pick_y_q;
				res.pick_index <= 6'(sel_q);
			end else begin
				res.pick_x     <= '0;
				res.pick_y     <= '0;
				res.pick_index <= '0;
			end
			unique case (cmd_i.res_status)
				ST_LOADED: res.remaining <= 7'(count_q + CW'(1));
				ST_CLEARED: res.remaining <= '0;
				ST_PICKED: res.remaining <= 7'(count_q - CW'(1));
				default: res.remaining <= 7'(count_q);
			endcase
		end
	end

	always_comb begin
		stat.cmd        = cmd_t'(in_q.cmd);
		stat.empty      = (count_q == '0);
		stat.full       = (count_q >= MAXC);
		stat.idx_last   = (CW'(idx_q) + CW'(1) >= count_q);
		stat.zero       = d2_zero;
		stat.cum_gt     = (cum_n > thr_q);
		stat.shift_done = (shift_next >= count_q);
	end

endmodule
`default_nettype wire

>>> sv/distance_weighted_waypoint_pick_core.sv
// Top level of the distance weighted waypoint pick block: ports, exponent
// register, output holding register. Depends on dwwp_pkg, dwwp_ctrl, dwwp_dp.
//
// One item at a time. Load, clear and empty-pick pass only through idle and done;
// a pick then weighs each held waypoint in the read, square, log, multiply and
// exp2 states, forms the threshold, runs the cumulative search and the one-port
// shift loop. A zero distance ends the pick after the log state.
// The result sits in an output register; the next item is taken as soon as
// the controller is back in idle.
`default_nettype none
module distance_weighted_waypoint_pick_core
	import dwwp_pkg::*;
#(
	parameter int MAX_WAYPOINTS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire in_item_t    in_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output out_item_t        out_data,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data
);

	logic [15:0] exponent_q;
	logic        in_ready, in_fire, out_load, busy;
	dp_cmd_t     dcmd;
	dp_stat_t    dstat;
	out_item_t   res;

	assign cfg_ready = 1'b1;
	assign in_stall  = !in_ready;
	assign in_fire   = in_valid && in_ready;
	assign busy      = out_valid && out_stall;
	assign out_data  = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exponent_q <= EXPONENT_RESET;
			out_valid  <= 1'b0;
		end else begin
			if (cfg_valid) exponent_q <= cfg_data;
			if (out_load) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	dwwp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.out_busy (busy),
		.stat     (dstat),
		.in_ready (in_ready),
		.out_load (out_load),
		.cmd_o    (dcmd)
	);

	dwwp_dp #(.MAX_WAYPOINTS(MAX_WAYPOINTS)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_data),
		.exponent (exponent_q),
		.cmd_i    (dcmd),
		.stat     (dstat),
		.res      (res)
	);

endmodule
`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for distance_weighted_waypoint_pick_core.
// Depends on dwwp_pkg and the core. It predicts each result and checks it field by field.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
	import dwwp_pkg::*;

	localparam int TABLE_DEPTH = 64;
	localparam int SETTLE_CYCLES = 700;
	localparam int STALL_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [15:0] cfg_data = '0;

	distance_weighted_waypoint_pick_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	in_item_t pending_items[$];
	out_item_t expected_picks[$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int error_count = 0;
	int items_sent = 0;
	int results_seen = 0;
	int picks_seen = 0;
	int idle_cycles = 0;

	// predictor copy of the table and the exponent register
	logic signed [23:0] trip_x[TABLE_DEPTH];
	logic signed [23:0] trip_y[TABLE_DEPTH];
	int trip_count = 0;
	logic [15:0] model_exponent = EXPONENT_RESET;

	function automatic longint unsigned sq_gap(logic signed [23:0] a, logic signed [23:0] b);
		longint d;
		d = longint'(a) - longint'(b);
		if (d < 0)
			d = -d;
		return longint'(d * d);
	endfunction

	// 1 / d^a via log2 / exp2 approximation, Q0.32 saturating, never zero
	function automatic logic [31:0] inv_pow_weight(longint unsigned d2, logic [15:0] ex);
		int k;
		longint unsigned rest, fr, n, f, m, w;
		longint lg, s;
		k = 63;
		while (k > 0 && d2[k] == 1'b0)
			k--;
		rest = d2 - (64'd1 << k);
		fr = (k >= 16) ? (rest >> (k - 16)) : (rest << (16 - k));
		lg = longint'(k) * 65536 + longint'(fr) - 16 * 65536;
		s = longint'({48'd0, ex}) * lg;
		if (s <= 0)
			return 32'hFFFF_FFFF;
		n = longint'(s) >> 29;
		f = s & 64'h1FFF_FFFF;
		m = (64'd1 << 32) - (f << 2);
		w = (n >= 33) ? 64'd0 : (m >> n);
		if (w > 64'hFFFF_FFFF)
			w = 64'hFFFF_FFFF;
		if (w == 0)
			w = 1;
		return w[31:0];
	endfunction

	function automatic void predict_pick(in_item_t it);
		out_item_t r;
		longint unsigned wt[TABLE_DEPTH];
		longint unsigned d2, total, thr, cum, fr;
		int sel;
		bit hit_zero;
		if (cmd_t'(it.cmd) == CMD_NONE)
			return;
		r = '0;
		total = 0;
		cum = 0;
		hit_zero = 1'b0;
		case (cmd_t'(it.cmd))
			CMD_LOAD: begin
				if (trip_count >= TABLE_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					trip_x[trip_count] = it.pos_x;
					trip_y[trip_count] = it.pos_y;
					trip_count++;
					r.status = ST_LOADED;
				end
			end
			CMD_CLEAR: begin
				trip_count = 0;
				r.status = ST_CLEARED;
			end
			default: begin
				if (trip_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					for (int i = 0; i < trip_count; i++) begin
						d2 = sq_gap(trip_x[i], it.pos_x) + sq_gap(trip_y[i], it.pos_y);
						if (d2 == 0) begin
							hit_zero = 1'b1;
							break;
						end
						wt[i] = inv_pow_weight(d2, model_exponent);
						total += wt[i];
					end
					if (hit_zero) begin
						r.status = ST_ZERO;
					end else begin
						fr = it.rand_frac;
						thr = fr * (total >> 32) + ((fr * (total & 64'hFFFF_FFFF)) >> 32);
						sel = trip_count - 1;
						for (int i = 0; i < trip_count; i++) begin
							cum += wt[i];
							if (cum > thr) begin
								sel = i;
								break;
							end
						end
						r.pick_x = trip_x[sel];
						r.pick_y = trip_y[sel];
						r.pick_index = sel[5:0];
						for (int i = sel; i + 1 < trip_count; i++) begin
							trip_x[i] = trip_x[i + 1];
							trip_y[i] = trip_y[i + 1];
						end
						trip_count--;
						r.status = ST_PICKED;
					end
				end
			end
		endcase
		r.remaining = trip_count[6:0];
		expected_picks.insert(expected_picks.size(), r);
	endfunction

	// driver
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			predict_pick(in_data);
			items_sent++;
		end
		if (in_valid && in_stall) begin
			in_valid <= 1'b1;
		end else if (arst_n && pending_items.size() > 0 &&
				$urandom_range(99) >= send_idle_pct) begin
			in_valid <= 1'b1;
			in_data <= pending_items.pop_front();
		end else begin
			in_valid <= 1'b0;
		end
	end

	task automatic report_mismatch(string field, longint got, longint want);
		$display("mismatch on %s at %0t: got %0h expected %0h", field, $time, got, want);
		error_count++;
	endtask

	// monitor
	always @(posedge clk) begin
		out_item_t want;
		if (out_valid && !out_stall) begin
			results_seen++;
			if (expected_picks.size() == 0) begin
				report_mismatch("unexpected item", out_data, 0);
			end else begin
				want = expected_picks.pop_front();
				if (want.status == ST_PICKED)
					picks_seen++;
				if (out_data.pick_x != want.pick_x)
					report_mismatch("pick_x", out_data.pick_x, want.pick_x);
				if (out_data.pick_y != want.pick_y)
					report_mismatch("pick_y", out_data.pick_y, want.pick_y);
				if (out_data.pick_index != want.pick_index)
					report_mismatch("pick_index", out_data.pick_index, want.pick_index);
				if (out_data.status != want.status)
					report_mismatch("status", out_data.status, want.status);
				if (out_data.remaining != want.remaining)
					report_mismatch("remaining", out_data.remaining, want.remaining);
			end
		end
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", idle_cycles);
			$display("FAIL");
			$finish;
		end
	end

	task automatic queue_item(cmd_t c, logic [23:0] x, logic [23:0] y, logic [31:0] f);
		in_item_t it;
		it.cmd = c;
		it.pos_x = x;
		it.pos_y = y;
		it.rand_frac = f;
		pending_items.insert(pending_items.size(), it);
	endtask

	task automatic wait_drained();
		while (pending_items.size() > 0 || in_valid || expected_picks.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_exponent(logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		model_exponent = v;
	endtask

	function automatic logic [31:0] pick_frac();
		case ($urandom_range(9))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// one trip: optional clear, a run of loads, then as many picks as loads or one more
	task automatic queue_trip(ref int count);
		int n;
		logic signed [23:0] cx, cy;
		logic signed [23:0] lx[$];
		logic signed [23:0] ly[$];
		int j;
		cx = $signed(24'($urandom_range(8388607))) >>> 1;
		cy = $signed(24'($urandom_range(8388607))) >>> 1;
		if ($urandom_range(2) == 0) begin
			queue_item(CMD_CLEAR, $urandom, $urandom, $urandom);
			count++;
		end
		n = ($urandom_range(9) == 0) ? TABLE_DEPTH + 1 : $urandom_range(1, 10);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) == 0) begin
				lx.insert(lx.size(), $urandom);
				ly.insert(ly.size(), $urandom);
			end else begin
				lx.insert(lx.size(), cx + $signed(24'($urandom_range(8190))) - 4095);
				ly.insert(ly.size(), cy + $signed(24'($urandom_range(8190))) - 4095);
			end
			queue_item(CMD_LOAD, lx[i], ly[i], $urandom);
			count++;
		end
		for (int i = 0; i < n + $urandom_range(1); i++) begin
			if ($urandom_range(7) == 0) begin
				j = $urandom_range(n - 1);
				queue_item(CMD_PICK, lx[j], ly[j], pick_frac());
			end else if ($urandom_range(9) == 0) begin
				queue_item(CMD_PICK, $urandom, $urandom, pick_frac());
			end else begin
				queue_item(CMD_PICK, cx + $signed(24'($urandom_range(8190))) - 4095,
					cy + $signed(24'($urandom_range(8190))) - 4095, pick_frac());
			end
			count++;
		end
		// noise, unused command included
		if ($urandom_range(3) == 0)
			queue_item(cmd_t'($urandom_range(3)), $urandom, $urandom, $urandom);
	endtask

	initial begin
		logic [15:0] exponents[6];
		int count;
		exponents = '{16'd4096, 16'd0, 16'hFFFF, 16'd1, 16'd2048, 16'd12288};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, every command, empty, zero distance, unused command
		queue_item(CMD_PICK, 24'h0, 24'h0, 32'h0);
		queue_item(CMD_LOAD, 24'h7FFFFF, 24'h7FFFFF, 32'h0);
		queue_item(CMD_LOAD, 24'h800000, 24'h800000, 32'hFFFF_FFFF);
		queue_item(CMD_LOAD, 24'h0, 24'h0, 32'h0);
		queue_item(CMD_LOAD, 24'h000100, 24'hFFFF00, 32'h0);
		queue_item(CMD_PICK, 24'h0, 24'h0, 32'h8000_0000);
		queue_item(CMD_NONE, 24'h123456, 24'h654321, 32'hDEAD_BEEF);
		queue_item(CMD_PICK, 24'h7FFFFF, 24'h800000, 32'hFFFF_FFFF);
		queue_item(CMD_PICK, 24'h000001, 24'h000000, 32'h0);
		queue_item(CMD_PICK, 24'h800000, 24'h7FFFFF, 32'h5555_5555);
		queue_item(CMD_PICK, 24'h0, 24'h1, 32'hAAAA_AAAA);
		queue_item(CMD_PICK, 24'h0, 24'h0, 32'h0);
		queue_item(CMD_LOAD, 24'h000010, 24'h000020, 32'h0);
		queue_item(CMD_CLEAR, 24'h0, 24'h0, 32'h0);
		queue_item(CMD_PICK, 24'h000010, 24'h000020, 32'h0);
		wait_drained();

		for (int ph = 0; ph < 6; ph++) begin
			if (ph > 0)
				write_exponent(exponents[ph]);
			case (ph / 2)
				0: begin send_idle_pct = 24; recv_idle_pct = 48; end
				1: begin send_idle_pct = 48; recv_idle_pct = 24; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			count = 0;
			while (count < 330)
				queue_trip(count);
			// sender holds off here until every result is back
			wait_drained();
		end

		$display("sent %0d items, checked %0d results, %0d of them picks",
			items_sent, results_seen, picks_seen);
		$display("six exponent settings including 0 and 65535, three idle patterns");
		if (error_count == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches", error_count);
			$display("FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire
